### rtl/odg_pkg.sv
// odg_pkg: shared types and constants for the odometry distance gate
// no dependencies

package odg_pkg;

    localparam int SIDE_W = 64;
    localparam logic [SIDE_W-1:0] SIDE_CAP = 64'h4000_0000_0000_0000;

    localparam logic [31:0] TARGET_RST   = 32'd65536;
    localparam logic [31:0] APPROACH_RST = 32'd9830;
    localparam logic [31:0] SCALE_RST    = 32'd429497;
    localparam logic [31:0] TIMEOUT_RST  = 32'd60000;

    typedef enum logic [1:0] {
        ACT_STEP   = 2'd0,
        ACT_START  = 2'd1,
        ACT_CANCEL = 2'd2,
        ACT_RESET  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_WAIT     = 2'd0,
        MODE_RUNNING  = 2'd1,
        MODE_TIMEOUT  = 2'd2,
        MODE_COMPLETE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_TARGET      = 3'd0,
        REG_APPROACH    = 3'd1,
        REG_LEFT_SCALE  = 3'd2,
        REG_RIGHT_SCALE = 3'd3,
        REG_LEFT_REV    = 3'd4,
        REG_RIGHT_REV   = 3'd5,
        REG_TIMEOUT     = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [31:0]        elapsed;
        logic signed [31:0] travelled;
        logic [31:0]        remaining;
        logic               approach;
        logic               timed_out;
        logic               reached;
    } gate_res_t;

endpackage

### rtl/odg_side.sv
// odg_side: signed Q48.16 distance of one wheel from its encoder delta
// depends on odg_pkg

module odg_side import odg_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic [COUNT_BITS-1:0] count,
    input  logic [COUNT_BITS-1:0] origin,
    input  logic [31:0]           scale,
    input  logic                  reverse,
    output logic signed [SIDE_W-1:0] side
);

    localparam int NCH    = (COUNT_BITS + 31) / 32;
    localparam int MAG_W  = NCH * 32;
    localparam int PROD_W = MAG_W + 32;

    logic [COUNT_BITS-1:0] delta;
    logic [COUNT_BITS-1:0] mag;
    logic [MAG_W-1:0]      mag_ext;
    logic [63:0]           part [NCH];
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     shifted;
    logic [SIDE_W-2:0]     mag_cap;
    logic                  neg;

    assign delta   = count - origin;
    assign neg     = delta[COUNT_BITS-1];
    assign mag     = neg ? (~delta + 1'b1) : delta;
    assign mag_ext = MAG_W'(mag);

    for (genvar i = 0; i < NCH; i++) begin : g_part
        assign part[i] = 64'(mag_ext[i*32 +: 32]) * 64'(scale);
    end

    always_comb begin
        prod = '0;
        for (int i = 0; i < NCH; i++) begin
            prod = prod + (PROD_W'(part[i]) << (32 * i));
        end
    end

    assign shifted = prod >> 16;
    assign mag_cap = (shifted > PROD_W'(SIDE_CAP)) ? SIDE_CAP[SIDE_W-2:0]
                                                   : shifted[SIDE_W-2:0];

    assign side = (neg ^ reverse) ? -$signed({1'b0, mag_cap}) : $signed({1'b0, mag_cap});

endmodule

### rtl/odg_gate.sv
// odg_gate: averages the two sides and forms remaining, approach and exit tests
// depends on odg_pkg

module odg_gate import odg_pkg::*; (
    input  logic signed [SIDE_W-1:0] left_side,
    input  logic signed [SIDE_W-1:0] right_side,
    input  logic [31:0]              now_time,
    input  logic [31:0]              start_time,
    input  logic [31:0]              target_distance,
    input  logic [31:0]              approach_distance,
    input  logic [31:0]              timeout_limit,
    output gate_res_t                res
);

    logic signed [SIDE_W:0]   sum;
    logic signed [SIDE_W:0]   half;
    logic signed [31:0]       avg;
    logic signed [33:0]       diff;
    logic [31:0]              rem;
    logic [31:0]              elapsed;
    logic                     fits;
    logic                     reached;

    assign sum  = {left_side[SIDE_W-1], left_side} + {right_side[SIDE_W-1], right_side};
    assign half = (sum >>> 1) + ((sum[SIDE_W] && sum[0]) ? 1 : 0);
    assign fits = (half[SIDE_W:31] == {(SIDE_W - 30){half[31]}});
    assign avg  = fits ? half[31:0] : (half[SIDE_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    assign diff    = $signed({2'b00, target_distance}) - 34'(avg);
    assign reached = diff[33] || (diff == '0);
    assign rem     = reached ? '0 : (diff[32] ? 32'hFFFF_FFFF : diff[31:0]);
    assign elapsed = now_time - start_time;

    always_comb begin
        res.elapsed   = elapsed;
        res.travelled = avg;
        res.remaining = rem;
        res.approach  = (rem <= approach_distance);
        res.timed_out = (elapsed >= timeout_limit);
        res.reached   = reached;
    end

endmodule

### rtl/odometry_distance_gate_unit.sv
// odometry_distance_gate_unit: top level with input register, held state and result
// depends on odg_pkg, odg_side, odg_gate
// result: the transaction is held in the input register, then registered into the held state and outputs
// throughput: one transaction per cycle while the output is free or m_ready is high, set by the state update pass
// reset: aresetn low clears mode to wait, held outputs, origins and start time,
// and loads the register defaults; no result is pending after reset

module odometry_distance_gate_unit import odg_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [31:0] s_left_count,
    input  logic signed [31:0] s_right_count,
    input  logic [31:0]        s_now_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_run_state,
    output logic [31:0]        m_elapsed_time,
    output logic signed [31:0] m_travelled,
    output logic [31:0]        m_remaining,
    output logic               m_approach_flag
);

    logic [31:0] target_reg, approach_reg, left_scale_reg, right_scale_reg, timeout_reg;
    logic        left_rev_reg, right_rev_reg;

    logic                  in_valid_reg;
    action_t               action_reg;
    logic [COUNT_BITS-1:0] left_reg, right_reg;
    logic [31:0]           now_reg;

    logic                  out_valid_reg, out_valid_next;
    mode_t                 mode_reg, mode_next;
    logic [COUNT_BITS-1:0] left_origin_reg, left_origin_next;
    logic [COUNT_BITS-1:0] right_origin_reg, right_origin_next;
    logic [31:0]           start_reg, start_next;
    logic [31:0]           elapsed_reg, elapsed_next;
    logic signed [31:0]    distance_reg, distance_next;
    logic [31:0]           remaining_reg, remaining_next;
    logic                  approach_flag_reg, approach_flag_next;

    logic signed [COUNT_BITS-1:0] left_in, right_in;
    logic signed [SIDE_W-1:0]     left_side, right_side;
    gate_res_t                    gate;
    logic                         advance;

    assign left_in  = COUNT_BITS'(s_left_count);
    assign right_in = COUNT_BITS'(s_right_count);

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg      <= TARGET_RST;
            approach_reg    <= APPROACH_RST;
            left_scale_reg  <= SCALE_RST;
            right_scale_reg <= SCALE_RST;
            left_rev_reg    <= 1'b0;
            right_rev_reg   <= 1'b0;
            timeout_reg     <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_TARGET:      target_reg      <= cfg_wr_data;
                REG_APPROACH:    approach_reg    <= cfg_wr_data;
                REG_LEFT_SCALE:  left_scale_reg  <= cfg_wr_data;
                REG_RIGHT_SCALE: right_scale_reg <= cfg_wr_data;
                REG_LEFT_REV:    left_rev_reg    <= cfg_wr_data[0];
                REG_RIGHT_REV:   right_rev_reg   <= cfg_wr_data[0];
                REG_TIMEOUT:     timeout_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= action_t'(s_action);
            left_reg   <= left_in;
            right_reg  <= right_in;
            now_reg    <= s_now_time;
        end
    end

    odg_side #(.COUNT_BITS(COUNT_BITS)) u_left (
        .count   (left_reg),
        .origin  (left_origin_reg),
        .scale   (left_scale_reg),
        .reverse (left_rev_reg),
        .side    (left_side)
    );

    odg_side #(.COUNT_BITS(COUNT_BITS)) u_right (
        .count   (right_reg),
        .origin  (right_origin_reg),
        .scale   (right_scale_reg),
        .reverse (right_rev_reg),
        .side    (right_side)
    );

    odg_gate u_gate (
        .left_side         (left_side),
        .right_side        (right_side),
        .now_time          (now_reg),
        .start_time        (start_reg),
        .target_distance   (target_reg),
        .approach_distance (approach_reg),
        .timeout_limit     (timeout_reg),
        .res               (gate)
    );

    always_comb begin
        mode_next          = mode_reg;
        left_origin_next   = left_origin_reg;
        right_origin_next  = right_origin_reg;
        start_next         = start_reg;
        elapsed_next       = elapsed_reg;
        distance_next      = distance_reg;
        remaining_next     = remaining_reg;
        approach_flag_next = approach_flag_reg;
        out_valid_next     = out_valid_reg && !m_ready;
        if (advance) begin
            out_valid_next = 1'b1;
            case (action_reg)
                ACT_START: begin
                    elapsed_next       = '0;
                    distance_next      = '0;
                    remaining_next     = '0;
                    approach_flag_next = 1'b0;
                    left_origin_next   = left_reg;
                    right_origin_next  = right_reg;
                    start_next         = now_reg;
                    mode_next          = MODE_RUNNING;
                end
                ACT_CANCEL: begin
                    mode_next          = MODE_WAIT;
                    approach_flag_next = 1'b0;
                end
                ACT_RESET: begin
                    elapsed_next       = '0;
                    distance_next      = '0;
                    remaining_next     = '0;
                    approach_flag_next = 1'b0;
                    mode_next          = MODE_WAIT;
                end
                ACT_STEP: begin
                    if (mode_reg == MODE_RUNNING) begin
                        elapsed_next       = gate.elapsed;
                        distance_next      = gate.travelled;
                        remaining_next     = gate.remaining;
                        approach_flag_next = gate.approach && !gate.timed_out
                                             && !gate.reached;
                        if (gate.timed_out) begin
                            mode_next = MODE_TIMEOUT;
                        end else if (gate.reached) begin
                            mode_next = MODE_COMPLETE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg     <= 1'b0;
            mode_reg          <= MODE_WAIT;
            left_origin_reg   <= '0;
            right_origin_reg  <= '0;
            start_reg         <= '0;
            elapsed_reg       <= '0;
            distance_reg      <= '0;
            remaining_reg     <= '0;
            approach_flag_reg <= 1'b0;
        end else begin
            out_valid_reg     <= out_valid_next;
            mode_reg          <= mode_next;
            left_origin_reg   <= left_origin_next;
            right_origin_reg  <= right_origin_next;
            start_reg         <= start_next;
            elapsed_reg       <= elapsed_next;
            distance_reg      <= distance_next;
            remaining_reg     <= remaining_next;
            approach_flag_reg <= approach_flag_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_run_state     = mode_reg;
    assign m_elapsed_time  = elapsed_reg;
    assign m_travelled     = distance_reg;
    assign m_remaining     = remaining_reg;
    assign m_approach_flag = approach_flag_reg;

endmodule
